// ----- src/waveform_duplicate_filter_top_defines.svh -----
// Assertion macros for the waveform duplicate filter.
// Clocked on clock and disabled during reset; no other dependencies.
`ifndef WAVEFORM_DUPLICATE_FILTER_TOP_DEFINES_SVH
`define WAVEFORM_DUPLICATE_FILTER_TOP_DEFINES_SVH

// Same-cycle implication.
`define WDF_ASSERT_NOW(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("waveform duplicate filter check failed");

// Next-cycle implication.
`define WDF_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("waveform duplicate filter check failed");

`endif

// ----- src/wdf_pkg.sv -----
// Shared types, constants and helpers for the waveform duplicate filter.
// No dependencies.
package wdf_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
   localparam int COUNT_BITS  = ADDR_BITS + 1;
   localparam int SAMPLE_BITS = 16;
   localparam int SAMPLE_W    = 16;
   localparam int ENTRY_W     = 16;
   localparam int HASH_W      = 32;
   localparam int DUP_W       = 16;

   localparam logic [HASH_W-1:0] HASH_MULT = 32'd16777619;
   localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
   localparam logic [DUP_W-1:0]  DUP_MAX   = {DUP_W{1'b1}};

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic [ENTRY_W-1:0]         entry_index;
      logic                       last_sample;
   } req_item_type;

   typedef struct packed {
      logic [ENTRY_W-1:0] entry_id;
      logic [HASH_W-1:0]  hash_value;
      logic               is_duplicate;
      logic [DUP_W-1:0]   duplicate_total;
      logic               table_full;
   } rsp_item_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic accept;        // fold the accepted sample into the hash
      logic search_clear;  // restart the table scan
      logic search_run;    // advance the table scan
      logic commit;        // update table and counter, load result register
   } cmd_type;

   typedef struct packed {
      logic search_done;
   } status_type;

   // Sign-extend the low SAMPLE_BITS bits of a sample to hash width.
   function automatic logic [HASH_W-1:0] widen_sample(logic [SAMPLE_W-1:0] raw);
      logic [SAMPLE_BITS-1:0] v;
      v = raw[SAMPLE_BITS-1:0];
      return {{(HASH_W-SAMPLE_BITS){v[SAMPLE_BITS-1]}}, v};
   endfunction

endpackage

// ----- src/wdf_ctrl.sv -----
// Controller state machine of the waveform duplicate filter.
// Depends on wdf_pkg.
module wdf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_last,
   output logic                req_ready,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   input  wdf_pkg::status_type status,
   output wdf_pkg::cmd_type    cmd
);

   wdf_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wdf_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         wdf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_last) begin
                  cmd.search_clear = 1'b1;
                  state_in         = wdf_pkg::ST_SEARCH;
               end
            end
         end
         wdf_pkg::ST_SEARCH: begin
            cmd.search_run = 1'b1;
            if (status.search_done) begin
               state_in = wdf_pkg::ST_FINISH;
            end
         end
         wdf_pkg::ST_FINISH: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit = 1'b1;
               state_in   = wdf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wdf_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- src/wdf_dp.sv -----
// Datapath of the waveform duplicate filter: hash, seen-hash table, counters.
// Depends on wdf_pkg.
module wdf_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  wdf_pkg::cmd_type      cmd,
   input  wdf_pkg::req_item_type req_item,
   output wdf_pkg::status_type   status,
   output wdf_pkg::rsp_item_type rsp_item
);

   logic [wdf_pkg::HASH_W-1:0]     hash_ff, hash_in;
   logic [wdf_pkg::HASH_W-1:0]     final_hash_ff;
   logic [wdf_pkg::ENTRY_W-1:0]    entry_ff;
   logic [wdf_pkg::HASH_W-1:0]     mix;
   logic [wdf_pkg::HASH_W-1:0]     step_hash;

   logic [wdf_pkg::HASH_W-1:0]     table_mem [wdf_pkg::TABLE_DEPTH];
   logic [wdf_pkg::HASH_W-1:0]     rd_data_ff;
   logic                           rd_pend_ff;
   logic                           rd_en;
   logic [wdf_pkg::COUNT_BITS-1:0] idx_ff;
   logic [wdf_pkg::COUNT_BITS-1:0] count_ff;
   logic                           found_ff;
   logic                           table_full;
   logic                           store_en;

   logic [wdf_pkg::DUP_W-1:0]      dup_ff, dup_in;
   wdf_pkg::rsp_item_type          rsp_ff;

   // FNV-1a step: xor, then multiply, low word kept
   assign mix       = hash_ff ^ wdf_pkg::widen_sample(req_item.sample);
   assign step_hash = mix * wdf_pkg::HASH_MULT;

   always_comb begin
      hash_in = hash_ff;
      if (cmd.accept) begin
         hash_in = req_item.last_sample ? wdf_pkg::FNV_BASIS : step_hash;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= wdf_pkg::FNV_BASIS;
      end else begin
         hash_ff <= hash_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && req_item.last_sample) begin
         final_hash_ff <= step_hash;
         entry_ff      <= req_item.entry_index;
      end
   end

   // Table scan: entries below count_ff are the valid ones.
   assign rd_en      = cmd.search_run && (idx_ff != count_ff);
   assign table_full = (count_ff == wdf_pkg::COUNT_BITS'(wdf_pkg::TABLE_DEPTH));
   assign store_en   = cmd.commit && !found_ff && !table_full;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= table_mem[idx_ff[wdf_pkg::ADDR_BITS-1:0]];
      end
      if (store_en) begin
         table_mem[count_ff[wdf_pkg::ADDR_BITS-1:0]] <= final_hash_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff     <= '0;
         rd_pend_ff <= 1'b0;
         found_ff   <= 1'b0;
         count_ff   <= '0;
      end else begin
         if (cmd.search_clear) begin
            idx_ff     <= '0;
            rd_pend_ff <= 1'b0;
            found_ff   <= 1'b0;
         end else begin
            rd_pend_ff <= rd_en;
            if (rd_en) begin
               idx_ff <= idx_ff + 1'b1;
            end
            if (rd_pend_ff && (rd_data_ff == final_hash_ff)) begin
               found_ff <= 1'b1;
            end
         end
         if (store_en) begin
            count_ff <= count_ff + 1'b1;
         end
      end
   end

   assign status.search_done = (idx_ff == count_ff) && !rd_pend_ff;

   always_comb begin
      dup_in = dup_ff;
      if (cmd.commit && found_ff && (dup_ff != wdf_pkg::DUP_MAX)) begin
         dup_in = dup_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dup_ff <= '0;
      end else begin
         dup_ff <= dup_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff.entry_id        <= entry_ff;
         rsp_ff.hash_value      <= final_hash_ff;
         rsp_ff.is_duplicate    <= found_ff;
         rsp_ff.duplicate_total <= dup_in;
         rsp_ff.table_full      <= !found_ff && table_full;
      end
   end

   assign rsp_item = rsp_ff;

endmodule

// ----- src/waveform_duplicate_filter_top.sv -----
// Flow: a non-last sample is folded into the hash register; a last sample is followed by a scan
// of the stored hashes, then a commit that loads the result register, which shows its item.
// Throughput: one sample per cycle within a waveform; after a last sample the next sample
// is taken only once the scan and commit are done, and later still while the result register waits.
// Reset: synchronous, clears hash to the FNV offset basis, table fill count and
// duplicate counter; table contents are not cleared (no clearing pass).
`include "waveform_duplicate_filter_top_defines.svh"

module waveform_duplicate_filter_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  wdf_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output wdf_pkg::rsp_item_type rsp_item
);

   // Command and status bundles between controller and datapath
   wdf_pkg::cmd_type    cmd;
   wdf_pkg::status_type status;

   // Controller: takes samples in idle, runs the table scan after a last
   // sample, then commits the result once the output register is free.
   wdf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_item.last_sample),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: FNV-1a hash fold, seen-hash memory, scan, counters and the
   // result register that parts the result side from the sample side.
   wdf_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_item (req_item),
      .status   (status),
      .rsp_item (rsp_item)
   );

   // A duplicate never reports a full table.
   `WDF_ASSERT_NOW(a_dup_not_full, rsp_valid, !(rsp_item.is_duplicate && rsp_item.table_full))
   // A commit always presents an item on the next cycle.
   `WDF_ASSERT_NEXT(a_commit_shows, cmd.commit, rsp_valid)
   // A last sample stops intake until its item is committed.
   `WDF_ASSERT_NEXT(a_last_blocks, req_valid && req_ready && req_item.last_sample, !req_ready)

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for waveform_duplicate_filter_top: drives waveform samples over
// the req_ channel, predicts each result and compares it field by field on the rsp_ channel.
// Depends on wdf_pkg and the RTL of the block only.
module tb;

   // Clock, reset and the block's ports. Each input of the block starts at a known value.
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   wdf_pkg::req_item_type req_item = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   wdf_pkg::rsp_item_type rsp_item;

   // Prediction state: the running hash, the set of stored hashes, the fill count of
   // the table and the saturating duplicate counter.
   logic [wdf_pkg::HASH_W-1:0] fold_hash = wdf_pkg::FNV_BASIS;
   bit                         stored_hashes[bit [wdf_pkg::HASH_W-1:0]];
   int unsigned                table_fill = 0;
   logic [wdf_pkg::DUP_W-1:0]  dup_count = '0;
   wdf_pkg::rsp_item_type      expected_results[$];

   // Waveforms already sent, kept so that they can be sent again as duplicates.
   logic [wdf_pkg::SAMPLE_W-1:0] sent_waves[64][40];
   int                           sent_wave_len[64];
   int                           sent_wave_count = 0;

   // Idle and stall rates, in percent, for the sender and the receiver.
   int                      sender_idle_pct = 0;
   int                      receiver_stall_pct = 0;
   int                      failures = 0;

   waveform_duplicate_filter_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Fold one sample into an FNV-1a hash: sign-extend it to hash width, XOR, multiply.
   function automatic logic [wdf_pkg::HASH_W-1:0] fnv_fold(
      logic [wdf_pkg::HASH_W-1:0] h, logic [wdf_pkg::SAMPLE_W-1:0] s);
      return (h ^ {{(wdf_pkg::HASH_W-wdf_pkg::SAMPLE_W){s[wdf_pkg::SAMPLE_W-1]}}, s})
             * wdf_pkg::HASH_MULT;
   endfunction

   // Advance the prediction by one accepted item; queue a result on a last sample.
   function automatic void track_sample(wdf_pkg::req_item_type item);
      logic [wdf_pkg::HASH_W-1:0] h;
      wdf_pkg::rsp_item_type      result;
      h = fnv_fold(fold_hash, item.sample);
      if (!item.last_sample) begin
         fold_hash = h;
         return;
      end
      result = '0;
      result.entry_id = item.entry_index;
      result.hash_value = h;
      if (stored_hashes.exists(h)) begin
         // A hash seen before is a duplicate; the counter sticks at its top value.
         result.is_duplicate = 1'b1;
         if (dup_count != wdf_pkg::DUP_MAX) dup_count++;
      end else if (table_fill < wdf_pkg::TABLE_DEPTH) begin
         stored_hashes[h] = 1'b1;
         table_fill++;
      end else begin
         // New hash with no room left: flag it, store nothing, count nothing.
         result.table_full = 1'b1;
      end
      result.duplicate_total = dup_count;
      fold_hash = wdf_pkg::FNV_BASIS;
      expected_results.push_back(result);
   endfunction

   function automatic void compare_field(string field, logic [wdf_pkg::HASH_W-1:0] want,
                                         logic [wdf_pkg::HASH_W-1:0] got);
      if (got !== want) begin
         failures++;
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
      end
   endfunction

   function automatic logic [wdf_pkg::SAMPLE_W-1:0] random_sample();
      case ($urandom_range(19))
         0:       return 16'sh8000;
         1:       return 16'sh7fff;
         2:       return '1;
         3:       return '0;
         default: return wdf_pkg::SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic logic [wdf_pkg::ENTRY_W-1:0] random_index();
      case ($urandom_range(19))
         0:       return '0;
         1:       return '1;
         default: return wdf_pkg::ENTRY_W'($urandom);
      endcase
   endfunction

   // Set the idling of both sides; the receiver picks up its rate at the next edge.
   task automatic set_idling(int sender_pct, int receiver_pct);
      sender_idle_pct = sender_pct;
      receiver_stall_pct <= receiver_pct;
   endtask

   // Send one item: idle first if the draw says so, then hold valid until accepted.
   // Valid is not dropped after acceptance, so back-to-back items keep it high.
   task automatic send_sample(logic [wdf_pkg::SAMPLE_W-1:0] s,
                              logic [wdf_pkg::ENTRY_W-1:0] index, logic last);
      wdf_pkg::req_item_type item;
      item.sample = s;
      item.entry_index = index;
      item.last_sample = last;
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid <= 1'b1;
      req_item <= item;
      do @(posedge clock); while (!req_ready);
      track_sample(item);
   endtask

   // Drop valid and hold off until every expected result has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
   endtask

   // Store one hash, then send that waveform again back to back; each repeat is a
   // duplicate and advances the counter.
   task automatic test_repeated_waveform();
      set_idling(0, 0);
      send_sample('0, '0, 1'b1);
      for (int n = 0; n < 20; n++)
         send_sample('0, wdf_pkg::ENTRY_W'(n), 1'b1);
      wait_drained();
   endtask

   // Extremes of every field, single-sample and multi-sample waveforms, indices on
   // non-last samples that must be ignored, and repeats that must be duplicates.
   task automatic test_directed_extremes();
      set_idling(34, 34);
      send_sample(16'sh8000, '0, 1'b1);
      send_sample(16'sh7fff, '1, 1'b1);
      send_sample('1, 16'd1, 1'b1);
      send_sample(16'd1, 16'd2, 1'b1);
      send_sample('0, 16'd3, 1'b1);
      send_sample(16'sh7fff, '1, 1'b0);
      send_sample(16'sh8000, '0, 1'b0);
      send_sample(16'sh5555, 16'haaaa, 1'b1);
      send_sample(16'sh7fff, 16'h1111, 1'b0);
      send_sample(16'sh8000, 16'h2222, 1'b0);
      send_sample(16'sh5555, 16'h5555, 1'b1);
      send_sample('1, '1, 1'b0);
      send_sample('1, 16'h1234, 1'b1);
      send_sample(16'sh7fff, 16'hedcb, 1'b1);
      wait_drained();
   endtask

   // Random waveforms in four idling phases. About a third of the waveforms replay
   // an earlier one, some of those with a single bit flipped to give a near miss.
   task automatic test_random_waveforms();
      int                           sent;
      int                           len;
      int                           slot;
      int                           pick;
      int                           flip;
      int                           word;
      int                           bit_pos;
      logic [wdf_pkg::SAMPLE_W-1:0] wave[40];
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       set_idling(0, 0);
            1:       set_idling(86, 0);
            2:       set_idling(0, 86);
            default: set_idling(34, 34);
         endcase
         sent = 0;
         while (sent < 175) begin
            pick = $urandom_range(99);
            if (pick < 35 && sent_wave_count > 0) begin
               slot = $urandom_range(sent_wave_count - 1);
               len = sent_wave_len[slot];
               for (int k = 0; k < len; k++) wave[k] = sent_waves[slot][k];
               if (pick < 10) begin
                  flip = $urandom_range(len * wdf_pkg::SAMPLE_W - 1);
                  word = flip / wdf_pkg::SAMPLE_W;
                  bit_pos = flip % wdf_pkg::SAMPLE_W;
                  wave[word][bit_pos] = ~wave[word][bit_pos];
               end
            end else begin
               // Mostly short waveforms, now and then a long one.
               len = (pick < 95) ? $urandom_range(1, 6) : $urandom_range(7, 40);
               for (int k = 0; k < len; k++) wave[k] = random_sample();
               if (sent_wave_count < 64) begin
                  slot = sent_wave_count;
                  sent_wave_count++;
               end else begin
                  slot = $urandom_range(63);
               end
               for (int k = 0; k < len; k++) sent_waves[slot][k] = wave[k];
               sent_wave_len[slot] = len;
            end
            for (int k = 0; k < len; k++)
               send_sample(wave[k], random_index(), k == len - 1);
            sent += len;
         end
         wait_drained();
      end
   endtask

   // Receiver: drive ready at each rising edge from the current stall rate.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Check each accepted result against the oldest expectation.
   always @(posedge clock) begin
      wdf_pkg::rsp_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            failures++;
            $display("%0t: unexpected result: expected none, actual %p", $time, rsp_item);
         end else begin
            want = expected_results.pop_front();
            compare_field("entry_id", wdf_pkg::HASH_W'(want.entry_id),
                          wdf_pkg::HASH_W'(rsp_item.entry_id));
            compare_field("hash_value", want.hash_value, rsp_item.hash_value);
            compare_field("is_duplicate", wdf_pkg::HASH_W'(want.is_duplicate),
                          wdf_pkg::HASH_W'(rsp_item.is_duplicate));
            compare_field("duplicate_total", wdf_pkg::HASH_W'(want.duplicate_total),
                          wdf_pkg::HASH_W'(rsp_item.duplicate_total));
            compare_field("table_full", wdf_pkg::HASH_W'(want.table_full),
                          wdf_pkg::HASH_W'(rsp_item.table_full));
         end
      end
   end

   // Main sequence: hold reset, run each test, drain, let the last table scan
   // finish, then report.
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_repeated_waveform();
      test_directed_extremes();
      test_random_waveforms();
      wait_drained();
      repeat (wdf_pkg::TABLE_DEPTH + 16) @(posedge clock);
      if (expected_results.size() != 0) failures++;
      if (failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Guard against a hang: several times the slowest correct run.
   initial begin
      #48000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
